@@ design/pnat_pkg.sv @@
// shared types and constants for the point and normal affine transform
`default_nettype none

package pnat_pkg;

    localparam int SLOT_BITS = 32;
    localparam int REG_BITS  = 64;
    localparam int NUM_REGS  = 6;
    localparam int IDX_BITS  = 3;

    // register indexes
    localparam int REG_ROW0_C01 = 0;
    localparam int REG_ROW0_C23 = 1;
    localparam int REG_ROW1_C01 = 2;
    localparam int REG_ROW1_C23 = 3;
    localparam int REG_ROW2_C01 = 4;
    localparam int REG_ROW2_C23 = 5;

    typedef struct packed {
        logic signed [SLOT_BITS-1:0] point_x;
        logic signed [SLOT_BITS-1:0] point_y;
        logic signed [SLOT_BITS-1:0] point_z;
        logic signed [SLOT_BITS-1:0] normal_x;
        logic signed [SLOT_BITS-1:0] normal_y;
        logic signed [SLOT_BITS-1:0] normal_z;
    } t_in_item;

    typedef struct packed {
        logic signed [SLOT_BITS-1:0] out_x;
        logic signed [SLOT_BITS-1:0] out_y;
        logic signed [SLOT_BITS-1:0] out_z;
        logic signed [SLOT_BITS-1:0] out_normal_x;
        logic signed [SLOT_BITS-1:0] out_normal_y;
        logic signed [SLOT_BITS-1:0] out_normal_z;
        logic                        singular;
        logic                        overflow;
    } t_out_item;

    typedef struct packed {
        logic zero;
        logic neg;
    } t_det_flags;

endpackage

`default_nettype wire

@@ design/pnat_cfg.sv @@
// matrix registers with cofactor and determinant pipeline
`default_nettype none

module pnat_cfg import pnat_pkg::*; #(
    parameter int E = 32,
    parameter int F = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [REG_BITS-1:0]  i_cfg_wdata,
    output logic signed [E-1:0]       o_m [3][4],
    output logic signed [2*E:0]       o_cof [3][3],
    output logic [3*E+2:0]            o_det_abs,
    output t_det_flags                o_det,
    output logic                      o_busy
);

    localparam int CW = 2 * E + 1;
    localparam int DW = 3 * E + 3;
    localparam logic [REG_BITS-1:0] ONE_Q = REG_BITS'(1) << F;
    localparam logic [2:0] SETTLE = 3'd6;

    logic [REG_BITS-1:0]    r_cfg [NUM_REGS];
    logic [2:0]             r_cnt;
    logic signed [2*E-1:0]  r_cp1 [3][3];
    logic signed [2*E-1:0]  r_cp2 [3][3];
    logic signed [CW-1:0]   r_cof [3][3];
    logic signed [CW-1:0]   r_dlo [3];
    logic signed [CW-1:0]   r_dhi [3];
    logic signed [DW-1:0]   r_dterm [3];
    logic signed [DW-1:0]   r_det;
    logic [DW-1:0]          r_det_abs;
    t_det_flags             r_det_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_cfg[i] <= '0;
            end
            r_cfg[REG_ROW0_C01] <= ONE_Q;
            r_cfg[REG_ROW1_C01] <= ONE_Q << SLOT_BITS;
            r_cfg[REG_ROW2_C23] <= ONE_Q;
        end else if (i_cfg_we && (i_cfg_idx < IDX_BITS'(NUM_REGS))) begin
            r_cfg[i_cfg_idx] <= i_cfg_wdata;
        end
    end

    // input held off until cofactors and determinant settle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= SETTLE;
        end else if (i_cfg_we) begin
            r_cnt <= SETTLE;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    for (genvar r = 0; r < 3; r++) begin : g_row
        for (genvar c = 0; c < 4; c++) begin : g_col
            assign o_m[r][c] = $signed(r_cfg[r*2 + (c >> 1)][(c & 1)*SLOT_BITS +: E]);
        end
    end

    for (genvar r = 0; r < 3; r++) begin : g_cof_r
        for (genvar c = 0; c < 3; c++) begin : g_cof_c
            localparam int R1 = (r + 1) % 3;
            localparam int R2 = (r + 2) % 3;
            localparam int C1 = (c + 1) % 3;
            localparam int C2 = (c + 2) % 3;
            always_ff @(posedge i_clk) begin
                r_cp1[r][c] <= o_m[R1][C1] * o_m[R2][C2];
                r_cp2[r][c] <= o_m[R1][C2] * o_m[R2][C1];
                r_cof[r][c] <= CW'(r_cp1[r][c]) - CW'(r_cp2[r][c]);
            end
        end
    end

    // determinant: first-row cofactors split into two narrow products
    for (genvar c = 0; c < 3; c++) begin : g_det
        always_ff @(posedge i_clk) begin
            r_dlo[c]   <= $signed({1'b0, r_cof[0][c][E-1:0]}) * o_m[0][c];
            r_dhi[c]   <= $signed(r_cof[0][c][CW-1:E]) * o_m[0][c];
            r_dterm[c] <= (DW'(r_dhi[c]) <<< E) + DW'(r_dlo[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_det            <= r_dterm[0] + r_dterm[1] + r_dterm[2];
        r_det_abs        <= r_det[DW-1] ? $unsigned(-r_det) : $unsigned(r_det);
        r_det_flags.zero <= (r_det == '0);
        r_det_flags.neg  <= r_det[DW-1];
    end

    assign o_cof     = r_cof;
    assign o_det_abs = r_det_abs;
    assign o_det     = r_det_flags;
    assign o_busy    = (r_cnt != '0);

endmodule

`default_nettype wire

@@ design/pnat_ctl.sv @@
// stage valid bits and per-stage load enables with bubble collapse
`default_nettype none

module pnat_ctl #(
    parameter int S = 39
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_out_ready,
    input  wire logic          i_busy,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output logic [S-1:0]       o_en
);

    logic [S-1:0] r_v;
    logic [S-1:0] n_v;
    logic         w_take;

    // a stage loads when any stage at or after it is empty, or the output drains
    always_comb begin
        for (int k = 0; k < S; k++) begin
            o_en[k] = i_out_ready || ((r_v | ((S'(1) << k) - S'(1))) != '1);
        end
    end

    assign o_in_ready  = o_en[0] && !i_busy;
    assign w_take      = i_in_valid && o_in_ready;
    assign o_out_valid = r_v[S-1];

    always_comb begin
        n_v[0] = o_en[0] ? w_take : r_v[0];
        for (int k = 1; k < S; k++) begin
            n_v[k] = o_en[k] ? r_v[k-1] : r_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

endmodule

`default_nettype wire

@@ design/pnat_point.sv @@
// point path: matrix times point, rounding, translation, saturation, delay line
`default_nettype none

module pnat_point import pnat_pkg::*; #(
    parameter int E = 32,
    parameter int F = 16,
    parameter int S = 39
) (
    input  wire logic              i_clk,
    input  wire logic [S-1:0]      i_en,
    input  wire t_in_item          i_item,
    input  wire logic signed [E-1:0] i_m [3][4],
    output logic signed [E-1:0]    o_pt [3],
    output logic                   o_ovf
);

    localparam int AW = 2 * E + 3;
    localparam int PW = 3 * E + 1;
    localparam logic signed [AW-1:0] RND  = AW'(1) <<< (F - 1);
    localparam logic signed [AW-1:0] PMAX = {{(AW-E+1){1'b0}}, {(E-1){1'b1}}};
    localparam logic signed [AW-1:0] PMIN = {{(AW-E+1){1'b1}}, {(E-1){1'b0}}};

    logic signed [E-1:0]    r_p [3];
    logic signed [2*E-1:0]  r_pp [3][3];
    logic signed [AW-1:0]   r_acc [3];
    logic signed [AW-1:0]   r_sh [3];
    logic [PW-1:0]          r_pd [4:S-1];
    logic [PW-1:0]          n_pd;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_p[0] <= i_item.point_x[E-1:0];
            r_p[1] <= i_item.point_y[E-1:0];
            r_p[2] <= i_item.point_z[E-1:0];
        end
    end

    for (genvar r = 0; r < 3; r++) begin : g_row
        for (genvar c = 0; c < 3; c++) begin : g_col
            always_ff @(posedge i_clk) begin
                if (i_en[1]) begin
                    r_pp[r][c] <= i_m[r][c] * r_p[c];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en[2]) begin
                r_acc[r] <= AW'(r_pp[r][0]) + AW'(r_pp[r][1]) + AW'(r_pp[r][2]) + RND;
            end
            if (i_en[3]) begin
                r_sh[r] <= (r_acc[r] >>> F) + AW'(i_m[r][3]);
            end
        end
    end

    always_comb begin
        n_pd = '0;
        for (int r = 0; r < 3; r++) begin
            if (r_sh[r] > PMAX) begin
                n_pd[r*E +: E] = PMAX[E-1:0];
                n_pd[PW-1]     = 1'b1;
            end else if (r_sh[r] < PMIN) begin
                n_pd[r*E +: E] = PMIN[E-1:0];
                n_pd[PW-1]     = 1'b1;
            end else begin
                n_pd[r*E +: E] = r_sh[r][E-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_pd[4] <= n_pd;
        end
    end

    // wait for the normal path
    for (genvar k = 5; k < S; k++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_pd[k] <= r_pd[k-1];
            end
        end
    end

    for (genvar r = 0; r < 3; r++) begin : g_out
        assign o_pt[r] = $signed(r_pd[S-1][r*E +: E]);
    end
    assign o_ovf = r_pd[S-1][PW-1];

endmodule

`default_nettype wire

@@ design/pnat_norm.sv @@
// normal path: cofactors times normal, then a restoring divide by the determinant
`default_nettype none

module pnat_norm import pnat_pkg::*; #(
    parameter int E = 32,
    parameter int F = 16,
    parameter int S = 39
) (
    input  wire logic                i_clk,
    input  wire logic [S-1:0]        i_en,
    input  wire t_in_item            i_item,
    input  wire logic signed [2*E:0] i_cof [3][3],
    input  wire logic [3*E+2:0]      i_det_abs,
    input  wire t_det_flags          i_det,
    output logic signed [E-1:0]      o_nrm [3],
    output logic                     o_ovf,
    output logic                     o_sing
);

    localparam int CW = 2 * E + 1;
    localparam int NW = 3 * E + 3;
    localparam int RW = (4 * E + 4 > 3 * E + F + 5) ? 4 * E + 4 : 3 * E + F + 5;
    localparam logic [E-1:0] HALF = {1'b1, {(E-1){1'b0}}};
    localparam logic [E-1:0] ONE  = {{(E-1){1'b0}}, 1'b1};

    logic signed [E-1:0]   r_n [3];
    logic signed [CW-1:0]  r_nlo [3][3];
    logic signed [CW-1:0]  r_nhi [3][3];
    logic signed [NW-1:0]  r_nt [3][3];
    logic signed [NW-1:0]  r_num [3];
    logic [NW-1:0]         w_abs [3];
    logic [RW-1:0]         r_dvd [3];
    logic                  r_neg4 [3];
    logic [RW-1:0]         r_rem [5:S-2][3];
    logic [E-1:0]          r_q [5:S-2][3];
    logic                  r_neg [5:S-2][3];
    logic                  r_big [5:S-2][3];
    logic [RW-1:0]         w_dd;
    logic [RW-1:0]         w_dd_top;
    logic signed [E-1:0]   n_nrm [3];
    logic                  n_ovf;
    logic signed [E-1:0]   r_nrm [3];
    logic                  r_ovf;
    logic                  r_sing;

    assign w_dd     = RW'(i_det_abs) << 1;
    assign w_dd_top = w_dd << E;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_n[0] <= i_item.normal_x[E-1:0];
            r_n[1] <= i_item.normal_y[E-1:0];
            r_n[2] <= i_item.normal_z[E-1:0];
        end
    end

    // wide cofactor split into low and high halves
    for (genvar r = 0; r < 3; r++) begin : g_row
        for (genvar c = 0; c < 3; c++) begin : g_col
            always_ff @(posedge i_clk) begin
                if (i_en[1]) begin
                    r_nlo[r][c] <= $signed({1'b0, i_cof[r][c][E-1:0]}) * r_n[c];
                    r_nhi[r][c] <= $signed(i_cof[r][c][CW-1:E]) * r_n[c];
                end
                if (i_en[2]) begin
                    r_nt[r][c] <= (NW'(r_nhi[r][c]) <<< E) + NW'(r_nlo[r][c]);
                end
            end
        end

        assign w_abs[r] = r_num[r][NW-1] ? $unsigned(-r_num[r]) : $unsigned(r_num[r]);

        always_ff @(posedge i_clk) begin
            if (i_en[3]) begin
                r_num[r] <= r_nt[r][0] + r_nt[r][1] + r_nt[r][2];
            end
            // round half away: (2|num|*2^F + |det|) / (2|det|)
            if (i_en[4]) begin
                r_dvd[r]  <= (RW'(w_abs[r]) << (F + 1)) + RW'(i_det_abs);
                r_neg4[r] <= r_num[r][NW-1] ^ i_det.neg;
            end
            if (i_en[5]) begin
                r_rem[5][r] <= r_dvd[r];
                r_big[5][r] <= (r_dvd[r] >= w_dd_top);
                r_neg[5][r] <= r_neg4[r];
                r_q[5][r]   <= '0;
            end
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 6; k <= S - 2; k++) begin : g_div
        localparam int SH = E + 5 - k;
        logic [RW-1:0] w_dsh;
        assign w_dsh = w_dd << SH;
        for (genvar r = 0; r < 3; r++) begin : g_lane
            always_ff @(posedge i_clk) begin
                if (i_en[k]) begin
                    if (r_rem[k-1][r] >= w_dsh) begin
                        r_rem[k][r] <= r_rem[k-1][r] - w_dsh;
                        r_q[k][r]   <= {r_q[k-1][r][E-2:0], 1'b1};
                    end else begin
                        r_rem[k][r] <= r_rem[k-1][r];
                        r_q[k][r]   <= {r_q[k-1][r][E-2:0], 1'b0};
                    end
                    r_neg[k][r] <= r_neg[k-1][r];
                    r_big[k][r] <= r_big[k-1][r];
                end
            end
        end
    end

    always_comb begin
        n_ovf = 1'b0;
        for (int r = 0; r < 3; r++) begin
            n_nrm[r] = '0;
            if (!i_det.zero) begin
                if (r_neg[S-2][r]) begin
                    if (r_big[S-2][r] || (r_q[S-2][r] > HALF)) begin
                        n_nrm[r] = $signed(HALF);
                        n_ovf    = 1'b1;
                    end else begin
                        n_nrm[r] = $signed(~r_q[S-2][r] + ONE);
                    end
                end else begin
                    if (r_big[S-2][r] || (r_q[S-2][r] >= HALF)) begin
                        n_nrm[r] = $signed(~HALF);
                        n_ovf    = 1'b1;
                    end else begin
                        n_nrm[r] = $signed(r_q[S-2][r]);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[S-1]) begin
            r_nrm  <= n_nrm;
            r_ovf  <= n_ovf;
            r_sing <= i_det.zero;
        end
    end

    assign o_nrm  = r_nrm;
    assign o_ovf  = r_ovf;
    assign o_sing = r_sing;

endmodule

`default_nettype wire

@@ design/point_normal_affine_transform.sv @@
// top level of the point and normal affine transform
//
//  channel  direction  handshake                      payload
//  in       request in i_in_valid / o_in_ready        i_in_item  (t_in_item)
//  out      result out o_out_valid / i_out_ready      o_out_item (t_out_item)
//  cfg      write      i_cfg_we                       i_cfg_idx, i_cfg_wdata
//
// one request per cycle while o_in_ready is high; the pipeline depth is set by the
// restoring divider that resolves one quotient bit per stage
// reset and every register write hold o_in_ready low while the
// cofactor and determinant pipeline settles
// a stalled output only blocks stages that are full; bubbles still fill
`default_nettype none

module point_normal_affine_transform import pnat_pkg::*; #(
    parameter int WORD_BITS     = 32,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire t_in_item            i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output t_out_item                o_out_item,
    input  wire logic                i_cfg_we,
    input  wire logic [IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [REG_BITS-1:0] i_cfg_wdata
);

    localparam int E = (WORD_BITS < SLOT_BITS) ? WORD_BITS : SLOT_BITS;
    localparam int F = FRACTION_BITS;
    localparam int S = E + 7;

    logic signed [E-1:0]   w_m [3][4];
    logic signed [2*E:0]   w_cof [3][3];
    logic [3*E+2:0]        w_det_abs;
    t_det_flags            w_det;
    logic                  w_busy;
    logic [S-1:0]          w_en;
    logic signed [E-1:0]   w_pt [3];
    logic                  w_povf;
    logic signed [E-1:0]   w_nrm [3];
    logic                  w_novf;
    logic                  w_sing;

    pnat_cfg #(.E(E), .F(F)) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_m         (w_m),
        .o_cof       (w_cof),
        .o_det_abs   (w_det_abs),
        .o_det       (w_det),
        .o_busy      (w_busy)
    );

    pnat_ctl #(.S(S)) u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_busy      (w_busy),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_en        (w_en)
    );

    pnat_point #(.E(E), .F(F), .S(S)) u_point (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_item (i_in_item),
        .i_m    (w_m),
        .o_pt   (w_pt),
        .o_ovf  (w_povf)
    );

    pnat_norm #(.E(E), .F(F), .S(S)) u_norm (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_item    (i_in_item),
        .i_cof     (w_cof),
        .i_det_abs (w_det_abs),
        .i_det     (w_det),
        .o_nrm     (w_nrm),
        .o_ovf     (w_novf),
        .o_sing    (w_sing)
    );

    always_comb begin
        o_out_item.out_x        = SLOT_BITS'(w_pt[0]);
        o_out_item.out_y        = SLOT_BITS'(w_pt[1]);
        o_out_item.out_z        = SLOT_BITS'(w_pt[2]);
        o_out_item.out_normal_x = SLOT_BITS'(w_nrm[0]);
        o_out_item.out_normal_y = SLOT_BITS'(w_nrm[1]);
        o_out_item.out_normal_z = SLOT_BITS'(w_nrm[2]);
        o_out_item.singular     = w_sing;
        o_out_item.overflow     = w_povf || w_novf;
    end

endmodule

`default_nettype wire

@@ design/pnat_checker.sv @@
// port-level checks for the point and normal affine transform
`default_nettype none

module pnat_checker import pnat_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_in_ready,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_item,
    input wire logic      i_cfg_we
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_item))
        else $error("stalled result changed");

    a_cfg_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !o_in_ready)
        else $error("request taken before matrix settled");

    a_reset_settle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("request taken right after reset");

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.singular |->
            (o_out_item.out_normal_x == '0) && (o_out_item.out_normal_y == '0) &&
            (o_out_item.out_normal_z == '0))
        else $error("singular result with nonzero normal");

endmodule

bind point_normal_affine_transform pnat_checker u_pnat_checker (.*);

`default_nettype wire

@@ tb/sv/tb_point_normal_affine_transform.sv @@
// testbench for the point and normal affine transform: directed and random requests
`default_nettype none

module tb_point_normal_affine_transform import pnat_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [191:0] wide_t;

    localparam int LATENCY   = 39;
    localparam int IDLE_WAIT = LATENCY + 12;
    localparam int STALL_LIM = 2000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    t_in_item            i_in_item;
    logic                o_out_valid;
    logic                i_out_ready;
    t_out_item           o_out_item;
    logic                i_cfg_we;
    logic [IDX_BITS-1:0] i_cfg_idx;
    logic [REG_BITS-1:0] i_cfg_wdata;

    logic [REG_BITS-1:0] matrix_regs [NUM_REGS];
    t_out_item           pending_results [$];
    int                  errors;
    int                  stall_cycles;
    bit                  no_gaps;

    point_normal_affine_transform dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic wide_t widen(logic signed [31:0] v);
        return v;
    endfunction

    function automatic logic [31:0] clamp(wide_t v, inout bit ovf);
        if (v < widen(32'sh8000_0000)) begin
            ovf = 1'b1;
            return 32'h8000_0000;
        end
        if (v > widen(32'sh7fff_ffff)) begin
            ovf = 1'b1;
            return 32'h7fff_ffff;
        end
        return v[31:0];
    endfunction

    function automatic t_out_item transform(t_in_item it);
        logic signed [31:0] m [3][4];
        logic signed [31:0] p [3];
        logic signed [31:0] n [3];
        wide_t     cof [3][3];
        wide_t     acc, det, num, an, ad, q;
        logic [31:0] res [6];
        bit        ovf;
        bit        neg;
        t_out_item o;
        ovf = 1'b0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 4; c++)
                m[r][c] = c[0] ? matrix_regs[r*2 + c/2][63:32]
                               : matrix_regs[r*2 + c/2][31:0];
        p = '{it.point_x, it.point_y, it.point_z};
        n = '{it.normal_x, it.normal_y, it.normal_z};
        for (int r = 0; r < 3; r++) begin
            acc = 0;
            for (int c = 0; c < 3; c++)
                acc = acc + widen(m[r][c]) * widen(p[c]);
            acc = (acc + (wide_t'(1) <<< 15)) >>> 16;
            acc = acc + widen(m[r][3]);
            res[r] = clamp(acc, ovf);
        end
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                cof[r][c] = widen(m[(r+1)%3][(c+1)%3]) * widen(m[(r+2)%3][(c+2)%3])
                          - widen(m[(r+1)%3][(c+2)%3]) * widen(m[(r+2)%3][(c+1)%3]);
        det = 0;
        for (int c = 0; c < 3; c++)
            det = det + cof[0][c] * widen(m[0][c]);
        o.singular = (det == 0);
        if (det == 0) begin
            res[3] = '0;
            res[4] = '0;
            res[5] = '0;
        end else begin
            ad = det < 0 ? -det : det;
            for (int r = 0; r < 3; r++) begin
                num = 0;
                for (int c = 0; c < 3; c++)
                    num = num + cof[r][c] * widen(n[c]);
                neg = (num < 0) != (det < 0);
                an  = num < 0 ? -num : num;
                // round to nearest, ties away from zero
                q   = ((an <<< 17) + ad) / (ad <<< 1);
                res[3+r] = clamp(neg ? -q : q, ovf);
            end
        end
        o.out_x        = res[0];
        o.out_y        = res[1];
        o.out_z        = res[2];
        o.out_normal_x = res[3];
        o.out_normal_y = res[4];
        o.out_normal_z = res[5];
        o.overflow     = ovf;
        return o;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected, expected none, actual %h",
                         $time, o_out_item);
                errors++;
            end else begin
                e = pending_results.pop_front();
                check_field("out_x", e.out_x, o_out_item.out_x);
                check_field("out_y", e.out_y, o_out_item.out_y);
                check_field("out_z", e.out_z, o_out_item.out_z);
                check_field("out_normal_x", e.out_normal_x, o_out_item.out_normal_x);
                check_field("out_normal_y", e.out_normal_y, o_out_item.out_normal_y);
                check_field("out_normal_z", e.out_normal_z, o_out_item.out_normal_z);
                check_field("singular", 32'(e.singular), 32'(o_out_item.singular));
                check_field("overflow", 32'(e.overflow), 32'(o_out_item.overflow));
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIM) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side back-pressure
    initial begin
        int gap;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        i_out_ready <= 1'b1;
        forever begin
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
            gap = no_gaps ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic send_request(t_in_item it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        pending_results.insert(pending_results.size(), transform(it));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // block must be idle; keeps write enable high across consecutive writes
    task automatic write_reg(int idx, logic [REG_BITS-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx[IDX_BITS-1:0];
        i_cfg_wdata <= val;
        @(posedge i_clk);
        if (idx < NUM_REGS) matrix_regs[idx] = val;
    endtask

    task automatic load_matrix(logic [31:0] mv [12]);
        drain_results();
        repeat (IDLE_WAIT) @(posedge i_clk);
        write_reg(REG_ROW0_C01, {mv[1],  mv[0]});
        write_reg(REG_ROW0_C23, {mv[3],  mv[2]});
        write_reg(REG_ROW1_C01, {mv[5],  mv[4]});
        write_reg(REG_ROW1_C23, {mv[7],  mv[6]});
        write_reg(REG_ROW2_C01, {mv[9],  mv[8]});
        write_reg(REG_ROW2_C23, {mv[11], mv[10]});
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_word(int mode);
        case (mode)
            0: rand_word = $urandom;
            1: rand_word = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            2: rand_word = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
            default: rand_word = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    function automatic t_in_item rand_request(int mode);
        t_in_item it;
        it.point_x  = rand_word(mode);
        it.point_y  = rand_word(mode);
        it.point_z  = rand_word(mode);
        it.normal_x = rand_word(mode);
        it.normal_y = rand_word(mode);
        it.normal_z = rand_word(mode);
        return it;
    endfunction

    // kinds: 0 full random, 1 modest, 2 singular (repeated row), 3 extremes
    task automatic load_random_matrix(int kind);
        logic [31:0] mv [12];
        for (int i = 0; i < 12; i++)
            case (kind)
                0: mv[i] = $urandom;
                3: mv[i] = rand_word(1);
                default: mv[i] = (i % 4 == 3) ? rand_word(2) : rand_word(3);
            endcase
        if (kind == 2)
            for (int c = 0; c < 3; c++) mv[8+c] = mv[c];
        load_matrix(mv);
    endtask

    task automatic test_identity_extremes();
        t_in_item it;
        logic [31:0] vals [5] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h0001_8000};
        for (int i = 0; i < 5; i++) begin
            it = '{vals[i], vals[(i+1)%5], vals[(i+2)%5], vals[(i+3)%5], vals[(i+4)%5], vals[i]};
            send_request(it);
        end
        send_request('{32'h0000_8000, 32'hffff_8000, 32'h0000_7fff, 32'h1, 32'hffff_ffff, 32'h0});
    endtask

    task automatic test_matrix_extremes();
        logic [31:0] mv [12];
        // all entries most negative, then most positive: saturation and singular
        foreach (mv[i]) mv[i] = 32'h8000_0000;
        load_matrix(mv);
        send_request('{32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'h7fff_ffff, 32'h0, 32'h8000_0000});
        send_request(rand_request(0));
        foreach (mv[i]) mv[i] = 32'h7fff_ffff;
        load_matrix(mv);
        send_request(rand_request(1));
        // diagonal extremes: nonsingular with huge determinant
        foreach (mv[i]) mv[i] = 32'h0;
        mv[0] = 32'h7fff_ffff; mv[5] = 32'h8000_0000; mv[10] = 32'h0000_0001;
        mv[3] = 32'h7fff_ffff; mv[7] = 32'h8000_0000; mv[11] = 32'h0001_0000;
        load_matrix(mv);
        for (int i = 0; i < 4; i++) send_request(rand_request(i));
        // zero matrix: singular, translation only
        foreach (mv[i]) mv[i] = 32'h0;
        mv[3] = 32'h1234_5678;
        load_matrix(mv);
        send_request(rand_request(0));
        // tiny determinant drives normals into saturation
        foreach (mv[i]) mv[i] = 32'h0;
        mv[0] = 32'h1; mv[5] = 32'h1; mv[10] = 32'h1;
        load_matrix(mv);
        send_request('{32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'hffff_0000, 32'h1});
        send_request('{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
    endtask

    task automatic test_bad_index();
        drain_results();
        repeat (IDLE_WAIT) @(posedge i_clk);
        write_reg(NUM_REGS, {$urandom, $urandom});
        write_reg(NUM_REGS + 1, {$urandom, $urandom});
        i_cfg_we <= 1'b0;
        send_request(rand_request(2));
        send_request(rand_request(3));
    endtask

    task automatic test_random_phases();
        int kind;
        for (int ph = 0; ph < 12; ph++) begin
            kind    = (ph < 4) ? ph : (($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 1);
            no_gaps = (ph % 4 == 3);
            load_random_matrix(kind);
            for (int i = 0; i < 150; i++) begin
                if (ph == 5 && i == 75) drain_results();
                send_request(rand_request($urandom_range(0, 3)));
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        logic [31:0] ident [12];
        ident        = '{32'h0001_0000, 0, 0, 0, 0, 32'h0001_0000, 0, 0,
                         0, 0, 32'h0001_0000, 0};
        errors       = 0;
        stall_cycles = 0;
        no_gaps      = 1'b0;
        matrix_regs  = '{64'h1_0000, 64'h0, 64'h1_0000_0000_0000, 64'h0, 64'h0, 64'h1_0000};
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_out_ready <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= '0;
        i_cfg_wdata <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_identity_extremes();
        test_matrix_extremes();
        load_matrix(ident);
        test_bad_index();
        test_random_phases();

        drain_results();
        repeat (IDLE_WAIT) @(posedge i_clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
